### hw/rtl/mtb_pkg.sv
// mtb_pkg: operation codes, timer entry type, controller/datapath command
// and status structs, and the per-entry tick update for the timer bank.
// No dependencies.
package mtb_pkg;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_START_ONCE  = 3'd1,
    OP_START_AUTO  = 3'd2,
    OP_STOP        = 3'd3,
    OP_CHECK       = 3'd4,
    OP_READ_RT     = 3'd5,
    OP_ELAPSED     = 3'd6,
    OP_START_DELAY = 3'd7
  } mtb_op_t;

  localparam logic [30:0] RUN_WRAP      = 31'h7FFF_FFFF;
  localparam logic [3:0]  TEN_TICKS     = 4'd10;
  localparam logic [6:0]  HUNDRED_TICKS = 7'd100;

  typedef struct packed {
    logic        flag;
    logic        auto_mode;
    logic [31:0] reload;
    logic [31:0] count;
  } mtb_entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_id;
    logic wr_start;
    logic wr_rmw;
    logic sweep_rd;
    logic load_out;
  } mtb_cmd_t;

  typedef struct packed {
    mtb_op_t op;
    logic    id_ok;
    logic    sweep_last;
  } mtb_sts_t;

  function automatic mtb_entry_t tick_entry(input mtb_entry_t e);
    mtb_entry_t  r;
    logic [31:0] dec;
    r   = e;
    dec = e.count - 32'd1;
    if (e.count != 32'd0) begin
      r.count = dec;
      if (dec == 32'd0) begin
        r.flag = 1'b1;
        if (e.auto_mode) begin
          r.count = e.reload;
        end
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/mtb_ctrl.sv
// mtb_ctrl: sequencing state machine for the timer bank.
// Depends on mtb_pkg; drives mtb_dp through mtb_cmd_t, reads mtb_sts_t.
module mtb_ctrl import mtb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  mtb_sts_t sts,
  output mtb_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_DRAIN = 6'b001000,
    S_RMW   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   is_start, is_rmw;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign is_start = (sts.op == OP_START_ONCE) || (sts.op == OP_START_AUTO);
  assign is_rmw   = (sts.op == OP_STOP) || (sts.op == OP_CHECK);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
        if (sts.op == OP_TICK) begin
          cmd.sweep_rd = 1'b1;
          state_nxt    = sts.sweep_last ? S_DRAIN : S_SWEEP;
        end else if (sts.id_ok && is_start) begin
          cmd.wr_start = 1'b1;
        end else if (sts.id_ok && is_rmw) begin
          cmd.rd_id = 1'b1;
          state_nxt = S_RMW;
        end
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_OUT;
      end
      S_RMW: begin
        cmd.wr_rmw = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted beat did not enter execute");

  a_sweep_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (sts.op == OP_TICK))
    else $error("sweep running for a non-tick beat");

  a_rmw_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW) |-> (sts.id_ok && is_rmw))
    else $error("read-modify-write for bad id or wrong operation");

endmodule

### hw/rtl/mtb_dp.sv
// mtb_dp: timer entry memory, run-time/delay/pulse counters, result staging
// and output payload registers. Depends on mtb_pkg; commanded by mtb_ctrl.
module mtb_dp import mtb_pkg::*; #(
  parameter int TIMER_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mtb_cmd_t    cmd,
  output mtb_sts_t    sts,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_period_ms,
  input  logic [30:0] in_last_time,
  output logic        out_expired,
  output logic [30:0] out_time_value,
  output logic        out_delay_done,
  output logic        out_pulse_1ms,
  output logic        out_pulse_10ms,
  output logic        out_pulse_100ms,
  output logic        out_id_error
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // captured beat
  logic [2:0]  op_raw_r;
  logic [7:0]  id_r;
  logic [31:0] period_r;
  logic [30:0] last_r;
  mtb_op_t     op;
  logic        id_ok;
  logic [IW-1:0] addr_id;

  // entry memory
  mtb_entry_t mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] vld_r;
  mtb_entry_t rd_data_r;
  logic       rd_vld_r;
  logic       rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  mtb_entry_t wr_data, entry_rd;

  logic [IW-1:0] sweep_idx_r;
  logic [IW-1:0] sw_addr_r;
  logic          sw_pend_r;

  // scalar state
  logic [30:0] run_time_r, run_time_nxt;
  logic [31:0] delay_cnt_r, delay_cnt_nxt;
  logic        delay_flag_r, delay_flag_nxt;
  logic [3:0]  ten_r, ten_nxt;
  logic [6:0]  hund_r, hund_nxt;
  logic [30:0] rt_inc;
  logic [3:0]  ten_inc;
  logic [6:0]  hund_inc;
  logic [31:0] dly_dec;
  logic        p10, p100;
  logic [31:0] diff;
  logic [30:0] elapsed;

  // staged result and output payload
  logic        res_exp_r, res_p1_r, res_p10_r, res_p100_r, res_err_r;
  logic [30:0] res_tval_r;
  logic        out_exp_r, out_dd_r, out_p1_r, out_p10_r, out_p100_r, out_err_r;
  logic [30:0] out_tval_r;

  assign op      = mtb_op_t'(op_raw_r);
  assign id_ok   = ({1'b0, id_r} < 9'(TIMER_COUNT));
  assign addr_id = id_r[IW-1:0];

  assign sts = mtb_sts_t'{op: op, id_ok: id_ok,
                          sweep_last: (sweep_idx_r == IW'(TIMER_COUNT - 1))};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_raw_r <= in_operation;
      id_r     <= in_timer_id;
      period_r <= in_period_ms;
      last_r   <= in_last_time;
    end
  end

  assign rd_en    = cmd.sweep_rd || cmd.rd_id;
  assign rd_addr  = cmd.sweep_rd ? sweep_idx_r : addr_id;
  assign entry_rd = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_id;
    wr_data = entry_rd;
    if (sw_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = sw_addr_r;
      wr_data = tick_entry(entry_rd);
    end else if (cmd.wr_rmw) begin
      wr_en        = 1'b1;
      wr_data.flag = 1'b0;
      if (op == OP_STOP) begin
        wr_data.count     = 32'd0;
        wr_data.auto_mode = 1'b0;
      end
    end else if (cmd.wr_start) begin
      wr_en             = 1'b1;
      wr_data.flag      = 1'b0;
      wr_data.auto_mode = (op == OP_START_AUTO);
      wr_data.reload    = period_r;
      wr_data.count     = period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.sweep_rd) begin
      sw_addr_r <= sweep_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      sw_pend_r   <= 1'b0;
      sweep_idx_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      sw_pend_r <= cmd.sweep_rd;
      if (cmd.capture) begin
        sweep_idx_r <= '0;
      end else if (cmd.sweep_rd) begin
        sweep_idx_r <= sweep_idx_r + IW'(1);
      end
    end
  end

  // scalar counters
  assign rt_inc   = run_time_r + 31'd1;
  assign ten_inc  = ten_r + 4'd1;
  assign hund_inc = hund_r + 7'd1;
  assign dly_dec  = delay_cnt_r - 32'd1;
  assign p10      = (ten_inc >= TEN_TICKS);
  assign p100     = (hund_inc >= HUNDRED_TICKS);
  assign diff     = {1'b0, run_time_r} - {1'b0, last_r};
  assign elapsed  = diff[31] ? (diff[30:0] - 31'd1) : diff[30:0];

  always_comb begin
    run_time_nxt   = run_time_r;
    delay_cnt_nxt  = delay_cnt_r;
    delay_flag_nxt = delay_flag_r;
    ten_nxt        = ten_r;
    hund_nxt       = hund_r;
    if (cmd.exec && (op == OP_TICK)) begin
      if (delay_cnt_r != 32'd0) begin
        delay_cnt_nxt = dly_dec;
        if (dly_dec == 32'd0) begin
          delay_flag_nxt = 1'b1;
        end
      end
      run_time_nxt = (rt_inc == RUN_WRAP) ? 31'd0 : rt_inc;
      ten_nxt      = p10 ? 4'd0 : ten_inc;
      hund_nxt     = p100 ? 7'd0 : hund_inc;
    end else if (cmd.exec && (op == OP_START_DELAY) && (period_r != 32'd0)) begin
      delay_cnt_nxt  = (period_r == 32'd1) ? 32'd2 : period_r;
      delay_flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_time_r   <= '0;
      delay_cnt_r  <= '0;
      delay_flag_r <= 1'b0;
      ten_r        <= '0;
      hund_r       <= '0;
    end else begin
      run_time_r   <= run_time_nxt;
      delay_cnt_r  <= delay_cnt_nxt;
      delay_flag_r <= delay_flag_nxt;
      ten_r        <= ten_nxt;
      hund_r       <= hund_nxt;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_exp_r  <= 1'b0;
      res_tval_r <= (op == OP_READ_RT) ? run_time_r :
                    (op == OP_ELAPSED) ? elapsed : 31'd0;
      res_p1_r   <= (op == OP_TICK);
      res_p10_r  <= (op == OP_TICK) && p10;
      res_p100_r <= (op == OP_TICK) && p100;
      res_err_r  <= !id_ok && (op == OP_START_ONCE || op == OP_START_AUTO ||
                               op == OP_STOP || op == OP_CHECK);
    end else if (cmd.wr_rmw && (op == OP_CHECK)) begin
      res_exp_r <= entry_rd.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_exp_r  <= res_exp_r;
      out_tval_r <= res_tval_r;
      out_dd_r   <= delay_flag_r;
      out_p1_r   <= res_p1_r;
      out_p10_r  <= res_p10_r;
      out_p100_r <= res_p100_r;
      out_err_r  <= res_err_r;
    end
  end

  assign out_expired     = out_exp_r;
  assign out_time_value  = out_tval_r;
  assign out_delay_done  = out_dd_r;
  assign out_pulse_1ms   = out_p1_r;
  assign out_pulse_10ms  = out_p10_r;
  assign out_pulse_100ms = out_p100_r;
  assign out_id_error    = out_err_r;

  a_sweep_no_alias: assert property (@(posedge clk) disable iff (!rst_n)
    (sw_pend_r && cmd.sweep_rd) |-> (sw_addr_r != sweep_idx_r))
    else $error("sweep read and write-back hit the same entry");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    sw_pend_r |-> !(cmd.wr_rmw || cmd.wr_start))
    else $error("sweep write-back collides with another write");

  a_rt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op == OP_TICK) |=> (run_time_r != RUN_WRAP))
    else $error("run time reached the wrap value");

endmodule

### hw/rtl/millisecond_timer_bank.sv
// A tick beat sweeps every entry, one per cycle, through the timer memory
// (one read, one write port), then drains; valid-id stop and check add a
// read-modify-write. One beat in flight; the next beat is accepted the cycle
// after its result enters the output register, even if that result is stalled.
// Reset (rst_n, synchronous, active low) clears counters, control and all
// timers at once through per-entry valid bits; no clearing pass.
module millisecond_timer_bank import mtb_pkg::*; #(
  parameter int TIMER_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_period_ms,
  input  logic [30:0] in_last_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_expired,
  output logic [30:0] out_time_value,
  output logic        out_delay_done,
  output logic        out_pulse_1ms,
  output logic        out_pulse_10ms,
  output logic        out_pulse_100ms,
  output logic        out_id_error
);

  mtb_cmd_t cmd;
  mtb_sts_t sts;

  mtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtb_dp #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_timer_id     (in_timer_id),
    .in_period_ms    (in_period_ms),
    .in_last_time    (in_last_time),
    .out_expired     (out_expired),
    .out_time_value  (out_time_value),
    .out_delay_done  (out_delay_done),
    .out_pulse_1ms   (out_pulse_1ms),
    .out_pulse_10ms  (out_pulse_10ms),
    .out_pulse_100ms (out_pulse_100ms),
    .out_id_error    (out_id_error)
  );

endmodule

### dv/millisecond_timer_bank_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for millisecond_timer_bank: beats are predicted by a
// behavioral model of the timer bank and checked field by field at the output.
// Depends on mtb_pkg (operation codes, RUN_WRAP) and the millisecond_timer_bank RTL.
module millisecond_timer_bank_tb;
  import mtb_pkg::*;

  localparam int TIMERS           = 8;
  localparam int CYCLE_LIMIT      = 900000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 40;

  typedef struct packed {
    logic        expired;
    logic [30:0] time_value;
    logic        delay_done;
    logic        pulse_1ms;
    logic        pulse_10ms;
    logic        pulse_100ms;
    logic        id_error;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = OP_TICK;
  logic [7:0]  in_timer_id = '0;
  logic [31:0] in_period_ms = '0;
  logic [30:0] in_last_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_expired;
  logic [30:0] out_time_value;
  logic        out_delay_done;
  logic        out_pulse_1ms;
  logic        out_pulse_10ms;
  logic        out_pulse_100ms;
  logic        out_id_error;

  // timer bank model state
  logic [31:0] tmr_count [TIMERS];
  logic [31:0] tmr_reload [TIMERS];
  logic        tmr_flag [TIMERS];
  logic        tmr_auto [TIMERS];
  logic [30:0] run_ms;
  logic [31:0] dly_count;
  logic        dly_flag;
  logic [3:0]  ten_div;
  logic [6:0]  hundred_div;

  response_t pending_responses[$];

  int  fail_count;
  int  beats_sent;
  int  ticks_sent;
  int  expiries_seen;
  int  id_errors_seen;
  int  pulse10_seen;
  int  pulse100_seen;
  int  cycle_count;
  bit  sender_idles;
  bit  receiver_stalls;
  int  hold_req_seq;
  int  hold_seen_seq;
  int  stall_left;
  int  free_left;

  millisecond_timer_bank #(.TIMER_COUNT(TIMERS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_timer_id     (in_timer_id),
    .in_period_ms    (in_period_ms),
    .in_last_time    (in_last_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_expired     (out_expired),
    .out_time_value  (out_time_value),
    .out_delay_done  (out_delay_done),
    .out_pulse_1ms   (out_pulse_1ms),
    .out_pulse_10ms  (out_pulse_10ms),
    .out_pulse_100ms (out_pulse_100ms),
    .out_id_error    (out_id_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_timer_bank();
    for (int k = 0; k < TIMERS; k++) begin
      tmr_count[k]  = '0;
      tmr_reload[k] = '0;
      tmr_flag[k]   = 1'b0;
      tmr_auto[k]   = 1'b0;
    end
    run_ms      = '0;
    dly_count   = '0;
    dly_flag    = 1'b0;
    ten_div     = '0;
    hundred_div = '0;
  endfunction

  // Updates the model for one beat and returns the response it should produce.
  function automatic response_t timer_bank_response(input mtb_op_t op, input logic [7:0] id,
                                                    input logic [31:0] period,
                                                    input logic [30:0] last);
    response_t r;
    logic      timer_op;
    r = '0;
    timer_op = (op == OP_START_ONCE) || (op == OP_START_AUTO) || (op == OP_STOP) ||
               (op == OP_CHECK);
    if (timer_op && id >= TIMERS) begin
      r.id_error = 1'b1;
    end else begin
      case (op)
        OP_TICK: begin
          if (dly_count != 0) begin
            dly_count = dly_count - 1;
            if (dly_count == 0) dly_flag = 1'b1;
          end
          for (int k = 0; k < TIMERS; k++) begin
            if (tmr_count[k] != 0) begin
              tmr_count[k] = tmr_count[k] - 1;
              if (tmr_count[k] == 0) begin
                tmr_flag[k] = 1'b1;
                if (tmr_auto[k]) tmr_count[k] = tmr_reload[k];
              end
            end
          end
          run_ms = run_ms + 31'd1;
          if (run_ms == RUN_WRAP) run_ms = '0;
          r.pulse_1ms = 1'b1;
          ten_div = ten_div + 4'd1;
          if (ten_div >= 4'd10) begin
            ten_div = '0;
            r.pulse_10ms = 1'b1;
          end
          hundred_div = hundred_div + 7'd1;
          if (hundred_div >= 7'd100) begin
            hundred_div = '0;
            r.pulse_100ms = 1'b1;
          end
        end
        OP_START_ONCE, OP_START_AUTO: begin
          tmr_count[id]  = period;
          tmr_reload[id] = period;
          tmr_flag[id]   = 1'b0;
          tmr_auto[id]   = (op == OP_START_AUTO);
        end
        OP_STOP: begin
          tmr_count[id] = '0;
          tmr_flag[id]  = 1'b0;
          tmr_auto[id]  = 1'b0;
        end
        OP_CHECK: begin
          if (tmr_flag[id]) begin
            tmr_flag[id] = 1'b0;
            r.expired    = 1'b1;
          end
        end
        OP_READ_RT: r.time_value = run_ms;
        OP_ELAPSED: begin
          if (run_ms >= last) r.time_value = run_ms - last;
          else r.time_value = RUN_WRAP - last + run_ms;
        end
        OP_START_DELAY: begin
          if (period != 0) begin
            dly_count = (period == 32'd1) ? 32'd2 : period;
            dly_flag  = 1'b0;
          end
        end
        default: ;
      endcase
    end
    r.delay_done = dly_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_beat(input mtb_op_t op, input logic [7:0] id, input logic [31:0] period,
                           input logic [30:0] last);
    int gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_timer_id  <= id;
    in_period_ms <= period;
    in_last_time <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_responses.push_back(timer_bank_response(op, id, period, last));
    beats_sent++;
    if (op == OP_TICK) ticks_sent++;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_beat();
    mtb_op_t     op;
    logic [7:0]  id;
    logic [31:0] period;
    logic [30:0] last;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) op = OP_TICK;
    else if (roll < 50) op = OP_START_ONCE;
    else if (roll < 58) op = OP_START_AUTO;
    else if (roll < 63) op = OP_STOP;
    else if (roll < 78) op = OP_CHECK;
    else if (roll < 84) op = OP_READ_RT;
    else if (roll < 92) op = OP_ELAPSED;
    else op = OP_START_DELAY;

    if ($urandom_range(0, 99) < 12) id = 8'($urandom_range(TIMERS, 255));
    else id = 8'($urandom_range(0, TIMERS - 1));

    roll = $urandom_range(0, 99);
    if (op == OP_START_DELAY) begin
      if (roll < 10) period = 0;
      else if (roll < 20) period = 1;
      else if (roll < 85) period = $urandom_range(2, 40);
      else if (roll < 95) period = $urandom_range(41, 500);
      else period = $urandom;
    end else begin
      if (roll < 10) period = 0;
      else if (roll < 80) period = $urandom_range(1, 24);
      else if (roll < 95) period = $urandom_range(25, 300);
      else period = $urandom;
    end

    roll = $urandom_range(0, 99);
    if (roll < 45) last = (run_ms > 31'd50) ? 31'(run_ms - $urandom_range(0, 50)) : '0;
    else if (roll < 55) last = 31'(run_ms + $urandom_range(1, 20));
    else if (roll < 65) last = RUN_WRAP;
    else last = 31'($urandom);

    send_beat(op, id, period, last);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $display("%0t result beat with nothing expected", $time);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("expired", 32'(want.expired), 32'(out_expired));
        compare_field("time_value", 32'(want.time_value), 32'(out_time_value));
        compare_field("delay_done", 32'(want.delay_done), 32'(out_delay_done));
        compare_field("pulse_1ms", 32'(want.pulse_1ms), 32'(out_pulse_1ms));
        compare_field("pulse_10ms", 32'(want.pulse_10ms), 32'(out_pulse_10ms));
        compare_field("pulse_100ms", 32'(want.pulse_100ms), 32'(out_pulse_100ms));
        compare_field("id_error", 32'(want.id_error), 32'(out_id_error));
        if (out_expired) expiries_seen++;
        if (out_id_error) id_errors_seen++;
        if (out_pulse_10ms) pulse10_seen++;
        if (out_pulse_100ms) pulse100_seen++;
      end
    end
  end

  // receiver stall generator; a long hold is requested by bumping hold_req_seq
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      free_left  = 0;
    end else if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq = hold_req_seq;
      stall_left    = LONG_HOLD_CYCLES - 1;
      out_stall     <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!receiver_stalls) begin
      out_stall <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      free_left  = $urandom_range(0, 6);
      stall_left = pick_gap();
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d beats still outstanding", $time, pending_responses.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed_cases();
    send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_READ_RT, 8'hFF, 32'hFFFF_FFFF, RUN_WRAP);
    send_beat(OP_ELAPSED, 8'd0, 32'd0, 31'd0);
    send_beat(OP_ELAPSED, 8'd0, 32'd0, RUN_WRAP);
    send_beat(OP_ELAPSED, 8'd0, 32'd0, 31'h7FFF_FFFE);
    send_beat(OP_START_ONCE, 8'd0, 32'd2, 31'd0);
    send_beat(OP_START_AUTO, 8'(TIMERS - 1), 32'd1, 31'd0);
    send_beat(OP_START_ONCE, 8'd3, 32'd0, 31'd0);
    send_beat(OP_START_AUTO, 8'd5, 32'hFFFF_FFFF, 31'd0);
    send_beat(OP_START_AUTO, 8'd6, 32'd0, 31'd0);
    send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_CHECK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_CHECK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_CHECK, 8'(TIMERS - 1), 32'd0, 31'd0);
    send_beat(OP_STOP, 8'(TIMERS - 1), 32'd0, 31'd0);
    send_beat(OP_CHECK, 8'(TIMERS - 1), 32'd0, 31'd0);
    send_beat(OP_START_ONCE, 8'(TIMERS), 32'd4, 31'd0);
    send_beat(OP_START_AUTO, 8'hFF, 32'd4, 31'd0);
    send_beat(OP_STOP, 8'h80, 32'd0, 31'd0);
    send_beat(OP_CHECK, 8'hC8, 32'd0, 31'd0);
    send_beat(OP_START_DELAY, 8'd0, 32'd0, 31'd0);
    send_beat(OP_START_DELAY, 8'd0, 32'd1, 31'd0);
    send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    send_beat(OP_START_DELAY, 8'd0, 32'hFFFF_FFFF, 31'd0);
    wait_drained();
  endtask

  task automatic test_pulse_dividers();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    for (int n = 0; n < 100; n++) begin
      if (n % 7 == 3) send_beat(OP_READ_RT, 8'd0, 32'd0, 31'd0);
      else send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    end
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    for (int n = 0; n < 100; n++) send_beat(OP_TICK, 8'd0, 32'd0, 31'd0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 1450; n++) begin
      if (n % 300 == 0) begin
        sender_idles    = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
      end
      send_random_beat();
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b1;
    for (int rep = 0; rep < 2; rep++) begin
      hold_req_seq++;
      for (int n = 0; n < 20; n++) send_random_beat();
    end
    wait_drained();
  endtask

  task automatic test_drain_between_bursts();
    sender_idles = 1'b1;
    for (int rep = 0; rep < 4; rep++) begin
      for (int n = 0; n < 10; n++) send_random_beat();
      wait_drained();
    end
  endtask

  initial begin
    clear_timer_bank();
    fail_count      = 0;
    beats_sent      = 0;
    ticks_sent      = 0;
    expiries_seen   = 0;
    id_errors_seen  = 0;
    pulse10_seen    = 0;
    pulse100_seen   = 0;
    cycle_count     = 0;
    hold_req_seq    = 0;
    hold_seen_seq   = 0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_pulse_dividers();
    test_random_traffic();
    test_output_backpressure();
    test_drain_between_bursts();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d beats (%0d ticks): %0d timer expiries, %0d bad-id beats,",
             beats_sent, ticks_sent, expiries_seen, id_errors_seen);
    $display("%0d 10 ms and %0d 100 ms pulses, with random and long output stalls.",
             pulse10_seen, pulse100_seen);
    if (fail_count == 0 && pending_responses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
